// File: hdl/fmc_pkg.sv
// Shared constants, codes and control/status types of the mutex coordinator.
package fmc_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int COUNT_ENTRIES = 1024;

    localparam int ID_W    = 16;
    localparam int PORT_W  = 10;
    localparam int CNT_W   = 32;
    localparam int KIND_W  = 2;
    localparam int LEVEL_W = 7;

    localparam int QAW   = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CAW   = $clog2(COUNT_ENTRIES);
    localparam int QW    = ID_W + PORT_W;

    localparam logic [ID_W:0] CNT_LIM = (ID_W + 1)'(COUNT_ENTRIES);

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_REL  = 2'd1,
        REQ_PASS = 2'd2,
        REQ_READ = 2'd3
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_GRANT = 2'd1,
        KIND_COUNT = 2'd2,
        KIND_DROP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  enq;
        logic  q_rd;
        logic  deq;
        logic  cnt_rd;
        logic  cnt_src;
        logic  cnt_wr;
        logic  clr;
        logic  release_res;
        logic  emit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic q_full;
        logic can_grant;
        logic clr_last;
    } t_stat;

endpackage

// File: hdl/fifo_mutex_coordinator_unit.sv
// Top level of the FIFO mutex coordinator: controller plus datapath.
// o_done pulses once the result is registered: straight from the execute state for request,
// release and a refused grant pass; after the count-table read for a count read; after the
// queue RAM read and then the count-table read-modify-write for a granted pass. A new request
// is taken only while busy is low, so each item finishes before the next is accepted.
// The receiver cannot stall; o_done is high for one cycle per result. Reset is synchronous,
// active low; busy then stays high while the COUNT_ENTRIES (1024) count entries are zeroed.
module fifo_mutex_coordinator_unit
    import fmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [PORT_W-1:0]  i_reply_port,
    output logic               o_done,
    output logic [KIND_W-1:0]  o_result_kind,
    output logic [ID_W-1:0]    o_grant_id,
    output logic [PORT_W-1:0]  o_grant_port,
    output logic [CNT_W-1:0]   o_count_value,
    output logic               o_resource_free,
    output logic [LEVEL_W-1:0] o_queue_level
);

    t_cmd  cmd;
    t_stat stat;

    fmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    fmc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_proc_id       (i_proc_id),
        .i_reply_port    (i_reply_port),
        .o_stat          (stat),
        .o_result_kind   (o_result_kind),
        .o_grant_id      (o_grant_id),
        .o_grant_port    (o_grant_port),
        .o_count_value   (o_count_value),
        .o_resource_free (o_resource_free),
        .o_queue_level   (o_queue_level)
    );

endmodule

// File: hdl/fmc_ram.sv
// Generic simple dual-port RAM with registered read.
module fmc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fmc_ctrl.sv
// Sequencing state machine of the mutex coordinator.
module fmc_ctrl
    import fmc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_QWAIT,
        S_CWAIT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;
    t_cmd   cmd;

    always_comb begin
        cmd      = '0;
        cmd.kind = KIND_NONE;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr = 1'b1;
            end
            S_IDLE: begin
                cmd.load = i_start;
            end
            S_EXEC: begin
                unique case (i_stat.req)
                    REQ_ENQ: begin
                        cmd.emit = 1'b1;
                        if (i_stat.q_full) begin
                            cmd.kind = KIND_DROP;
                        end else begin
                            cmd.enq = 1'b1;
                        end
                    end
                    REQ_REL: begin
                        cmd.release_res = 1'b1;
                        cmd.emit        = 1'b1;
                    end
                    REQ_PASS: begin
                        if (i_stat.can_grant) begin
                            cmd.q_rd = 1'b1;
                        end else begin
                            cmd.emit = 1'b1;
                        end
                    end
                    REQ_READ: begin
                        cmd.cnt_rd = 1'b1;
                    end
                    default: begin
                        cmd.emit = 1'b1;
                    end
                endcase
            end
            S_QWAIT: begin
                cmd.deq     = 1'b1;
                cmd.cnt_rd  = 1'b1;
                cmd.cnt_src = 1'b1;
            end
            S_CWAIT: begin
                cmd.emit = 1'b1;
                if (i_stat.req == REQ_PASS) begin
                    cmd.kind   = KIND_GRANT;
                    cmd.cnt_wr = 1'b1;
                end else begin
                    cmd.kind = KIND_COUNT;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_done <= cmd.emit;
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (i_stat.req == REQ_PASS && i_stat.can_grant) begin
                        r_state <= S_QWAIT;
                    end else if (i_stat.req == REQ_READ) begin
                        r_state <= S_CWAIT;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_QWAIT: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_busy  <= 1'b1;
                end
            endcase
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// File: hdl/fmc_dp.sv
// Datapath: wait queue, grant-count table, lock flag and result registers.
module fmc_dp
    import fmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_req_type,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [PORT_W-1:0]  i_reply_port,
    output t_stat              o_stat,
    output logic [KIND_W-1:0]  o_result_kind,
    output logic [ID_W-1:0]    o_grant_id,
    output logic [PORT_W-1:0]  o_grant_port,
    output logic [CNT_W-1:0]   o_count_value,
    output logic               o_resource_free,
    output logic [LEVEL_W-1:0] o_queue_level
);

    t_req              r_type;
    logic [ID_W-1:0]   r_id;
    logic [PORT_W-1:0] r_port;
    logic [ID_W-1:0]   r_gid;
    logic [PORT_W-1:0] r_gport;
    logic [QAW-1:0]    r_head, n_head;
    logic [QAW-1:0]    r_tail, n_tail;
    logic [LVL_W-1:0]  r_qcnt, n_qcnt;
    logic              r_free, n_free;
    logic [CAW-1:0]    r_clr;

    logic [KIND_W-1:0] r_res_kind;
    logic [ID_W-1:0]   r_res_gid;
    logic [PORT_W-1:0] r_res_gport;
    logic [CNT_W-1:0]  r_res_cnt;
    logic              r_res_free;
    logic [LVL_W-1:0]  r_res_lvl;

    logic [QW-1:0]     q_rdata;
    logic [ID_W-1:0]   q_rid;
    logic [PORT_W-1:0] q_rport;
    logic [CNT_W-1:0]  c_rdata;
    logic [CNT_W-1:0]  c_inc;
    logic [CNT_W-1:0]  c_wdata;
    logic [CAW-1:0]    c_waddr;
    logic [CAW-1:0]    c_raddr;
    logic              c_we;
    logic              id_in;
    logic              gid_in;
    logic [CNT_W-1:0]  res_cnt;

    assign q_rid   = q_rdata[QW-1:PORT_W];
    assign q_rport = q_rdata[PORT_W-1:0];
    assign id_in   = {1'b0, r_id} < CNT_LIM;
    assign gid_in  = {1'b0, r_gid} < CNT_LIM;
    assign c_inc   = (c_rdata == '1) ? c_rdata : c_rdata + CNT_W'(1);

    assign c_we    = i_cmd.clr | (i_cmd.cnt_wr & gid_in);
    assign c_waddr = i_cmd.clr ? r_clr : r_gid[CAW-1:0];
    assign c_wdata = i_cmd.clr ? '0 : c_inc;
    assign c_raddr = i_cmd.cnt_src ? q_rid[CAW-1:0] : r_id[CAW-1:0];

    fmc_ram #(.W(QW), .D(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq),
        .i_waddr (r_tail),
        .i_wdata ({r_id, r_port}),
        .i_re    (i_cmd.q_rd),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    fmc_ram #(.W(CNT_W), .D(COUNT_ENTRIES)) u_counts (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (i_cmd.cnt_rd),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_qcnt = r_qcnt;
        n_free = r_free;
        if (i_cmd.enq) begin
            n_tail = (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QAW'(1);
            n_qcnt = r_qcnt + LVL_W'(1);
        end
        if (i_cmd.deq) begin
            n_head = (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QAW'(1);
            n_qcnt = r_qcnt - LVL_W'(1);
            n_free = 1'b0;
        end
        if (i_cmd.release_res) begin
            n_free = 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.kind)
            KIND_GRANT: res_cnt = gid_in ? c_inc : '0;
            KIND_COUNT: res_cnt = id_in ? c_rdata : '0;
            default:    res_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_qcnt <= '0;
            r_free <= 1'b1;
            r_clr  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_qcnt <= n_qcnt;
            r_free <= n_free;
            if (i_cmd.clr) begin
                r_clr <= r_clr + CAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= t_req'(i_req_type);
            r_id   <= i_proc_id;
            r_port <= i_reply_port;
        end
        if (i_cmd.deq) begin
            r_gid   <= q_rid;
            r_gport <= q_rport;
        end
        if (i_cmd.emit) begin
            r_res_kind  <= i_cmd.kind;
            r_res_gid   <= (i_cmd.kind == KIND_GRANT) ? r_gid : '0;
            r_res_gport <= (i_cmd.kind == KIND_GRANT) ? r_gport : '0;
            r_res_cnt   <= res_cnt;
            r_res_free  <= n_free;
            r_res_lvl   <= n_qcnt;
        end
    end

    assign o_stat.req       = r_type;
    assign o_stat.q_full    = (r_qcnt == LVL_W'(QUEUE_DEPTH));
    assign o_stat.can_grant = r_free && (r_qcnt != '0);
    assign o_stat.clr_last  = (r_clr == CAW'(COUNT_ENTRIES - 1));

    assign o_result_kind   = r_res_kind;
    assign o_grant_id      = r_res_gid;
    assign o_grant_port    = r_res_gport;
    assign o_count_value   = r_res_cnt;
    assign o_resource_free = r_res_free;
    assign o_queue_level   = LEVEL_W'(r_res_lvl);

endmodule

// File: hdl/fmc_chk.sv
// Port-level checker of the mutex coordinator, bound to the top level.
module fmc_chk
    import fmc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [KIND_W-1:0]  o_result_kind,
    input logic               o_resource_free,
    input logic [LEVEL_W-1:0] o_queue_level
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on consecutive cycles");

    a_grant_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result_kind == KIND_GRANT |-> !o_resource_free)
        else $error("grant reported with resource free");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result_kind == KIND_DROP |-> o_queue_level == LEVEL_W'(QUEUE_DEPTH))
        else $error("request dropped while queue not full");

endmodule

bind fifo_mutex_coordinator_unit fmc_chk u_fmc_chk (.*);

// File: verif/fmc_lock_checker.sv
// Reply checker for the FIFO mutex coordinator: predicts every transfer and compares on o_done.
module fmc_lock_checker
    import fmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_req_type,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [PORT_W-1:0]  i_reply_port,
    input  logic               i_done,
    input  logic [KIND_W-1:0]  i_result_kind,
    input  logic [ID_W-1:0]    i_grant_id,
    input  logic [PORT_W-1:0]  i_grant_port,
    input  logic [CNT_W-1:0]   i_count_value,
    input  logic               i_resource_free,
    input  logic [LEVEL_W-1:0] i_queue_level,
    output int                 o_fail_count,
    output int                 o_replies_due
);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
    } t_waiter;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    gid;
        logic [PORT_W-1:0]  gport;
        logic [CNT_W-1:0]   cnt;
        logic               free;
        logic [LEVEL_W-1:0] level;
    } t_lock_reply;

    t_waiter          waiters[$];
    t_lock_reply      lock_replies[$];
    logic [CNT_W-1:0] grant_tally [COUNT_ENTRIES];
    logic             res_free = 1'b1;
    int               mismatches = 0;
    t_lock_reply      got;
    t_lock_reply      want;

    function automatic t_lock_reply arbitrate_item(input t_req op,
                                                   input logic [ID_W-1:0] pid,
                                                   input logic [PORT_W-1:0] pport);
        t_lock_reply r;
        t_waiter     head;
        r = '0;
        r.kind = KIND_NONE;
        case (op)
            REQ_ENQ: begin
                if (waiters.size() >= QUEUE_DEPTH) begin
                    r.kind = KIND_DROP;
                end else begin
                    head.id = pid;
                    head.port = pport;
                    waiters.push_back(head);
                end
            end
            REQ_REL: begin
                res_free = 1'b1;
            end
            REQ_PASS: begin
                if (res_free && waiters.size() > 0) begin
                    head = waiters.pop_front();
                    res_free = 1'b0;
                    r.gid = head.id;
                    r.gport = head.port;
                    if (head.id < COUNT_ENTRIES) begin
                        if (grant_tally[head.id[CAW-1:0]] != '1)
                            grant_tally[head.id[CAW-1:0]]++;
                        r.cnt = grant_tally[head.id[CAW-1:0]];
                    end
                    r.kind = KIND_GRANT;
                end
            end
            default: begin
                if (pid < COUNT_ENTRIES)
                    r.cnt = grant_tally[pid[CAW-1:0]];
                r.kind = KIND_COUNT;
            end
        endcase
        r.free = res_free;
        r.level = LEVEL_W'(waiters.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            waiters.delete();
            lock_replies.delete();
            res_free = 1'b1;
            foreach (grant_tally[k]) grant_tally[k] = '0;
        end else begin
            if (i_done !== 1'b0) begin
                got.kind = t_kind'(i_result_kind);
                got.gid = i_grant_id;
                got.gport = i_grant_port;
                got.cnt = i_count_value;
                got.free = i_resource_free;
                got.level = i_queue_level;
                if (lock_replies.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected: kind=%0d id=%h port=%h cnt=%h free=%b lvl=%0d",
                                 got.kind, got.gid, got.gport, got.cnt, got.free, got.level);
                    mismatches++;
                end else begin
                    want = lock_replies.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("mismatch exp: kind=%0d id=%h port=%h cnt=%h free=%b lvl=%0d",
                                     want.kind, want.gid, want.gport, want.cnt, want.free,
                                     want.level);
                            $display("         got: kind=%0d id=%h port=%h cnt=%h free=%b lvl=%0d",
                                     got.kind, got.gid, got.gport, got.cnt, got.free, got.level);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy)
                lock_replies.push_back(arbitrate_item(t_req'(i_req_type), i_proc_id,
                                                      i_reply_port));
        end
        o_fail_count <= mismatches;
        o_replies_due <= lock_replies.size();
    end

endmodule

// File: verif/tb_fifo_mutex_coordinator_unit.sv
// Testbench top for the FIFO mutex coordinator: clock, reset, stimulus and verdict.
module tb_fifo_mutex_coordinator_unit;
    import fmc_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = REQ_ENQ;
    logic [ID_W-1:0]    i_proc_id = '0;
    logic [PORT_W-1:0]  i_reply_port = '0;
    logic               o_done;
    logic [KIND_W-1:0]  o_result_kind;
    logic [ID_W-1:0]    o_grant_id;
    logic [PORT_W-1:0]  o_grant_port;
    logic [CNT_W-1:0]   o_count_value;
    logic               o_resource_free;
    logic [LEVEL_W-1:0] o_queue_level;

    int fail_count;
    int replies_due;
    int idle_pct = 0;
    int items_sent = 0;
    int drain_wait;

    always #4 i_clk = ~i_clk;

    fifo_mutex_coordinator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_proc_id      (i_proc_id),
        .i_reply_port   (i_reply_port),
        .o_done         (o_done),
        .o_result_kind  (o_result_kind),
        .o_grant_id     (o_grant_id),
        .o_grant_port   (o_grant_port),
        .o_count_value  (o_count_value),
        .o_resource_free(o_resource_free),
        .o_queue_level  (o_queue_level)
    );

    fmc_lock_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req_type     (i_req_type),
        .i_proc_id      (i_proc_id),
        .i_reply_port   (i_reply_port),
        .i_done         (o_done),
        .i_result_kind  (o_result_kind),
        .i_grant_id     (o_grant_id),
        .i_grant_port   (o_grant_port),
        .i_count_value  (o_count_value),
        .i_resource_free(o_resource_free),
        .i_queue_level  (o_queue_level),
        .o_fail_count   (fail_count),
        .o_replies_due  (replies_due)
    );

    task automatic issue(input t_req op, input logic [ID_W-1:0] pid,
                         input logic [PORT_W-1:0] pport);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= op;
        i_proc_id <= pid;
        i_reply_port <= pport;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic wait_all_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (replies_due != 0);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return ID_W'($urandom_range(0, 15));
        else if (r < 85)
            return ID_W'($urandom_range(0, COUNT_ENTRIES - 1));
        return ID_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        return PORT_W'($urandom_range(0, 1023));
    endfunction

    task automatic lock_round();
        repeat ($urandom_range(0, 3)) issue(REQ_ENQ, pick_id(), pick_port());
        repeat ($urandom_range(1, 3)) begin
            issue(REQ_PASS, ID_W'($urandom_range(0, 65535)), pick_port());
            if ($urandom_range(1))
                issue(REQ_READ, pick_id(), pick_port());
            issue(REQ_REL, ID_W'($urandom_range(0, 65535)), pick_port());
        end
    endtask

    // overflow the wait queue, then grant part of it back out
    task automatic fill_and_drain();
        repeat (QUEUE_DEPTH + $urandom_range(1, 4)) issue(REQ_ENQ, pick_id(), pick_port());
        repeat ($urandom_range(20, 70)) begin
            issue(REQ_PASS, ID_W'($urandom_range(0, 65535)), pick_port());
            issue(REQ_REL, ID_W'($urandom_range(0, 65535)), pick_port());
        end
    endtask

    task automatic run_phase(input int pct, input int quota);
        int target;
        int r;
        target = items_sent + quota;
        idle_pct = pct;
        fill_and_drain();
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 2)
                fill_and_drain();
            else if (r < 80)
                lock_round();
            else
                repeat ($urandom_range(1, 4))
                    issue(t_req'($urandom_range(3)), ID_W'($urandom_range(0, 65535)),
                          pick_port());
            if ($urandom_range(199) == 0)
                wait_all_replies();
        end
        wait_all_replies();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(REQ_READ, 16'd0, 10'd0);
        issue(REQ_READ, 16'hFFFF, 10'h3FF);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_REL, 16'd7, 10'd0);
        issue(REQ_ENQ, 16'd0, 10'd0);
        issue(REQ_ENQ, 16'hFFFF, 10'h3FF);
        issue(REQ_ENQ, 16'd1023, 10'd1);
        issue(REQ_ENQ, 16'd1024, 10'd512);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_REL, 16'd0, 10'd0);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_REL, 16'd0, 10'd0);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_READ, 16'd1023, 10'd0);
        issue(REQ_REL, 16'd0, 10'd0);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_READ, 16'd1024, 10'd0);
        issue(REQ_READ, 16'd0, 10'd0);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_REL, 16'd0, 10'd0);
        issue(REQ_PASS, 16'd0, 10'd0);
        issue(REQ_ENQ, 16'h5555, 10'h2AA);
        issue(REQ_ENQ, 16'hAAAA, 10'h155);
        wait_all_replies();

        run_phase(24, 580);
        run_phase(79, 580);
        run_phase(0, 580);

        start <= 1'b0;
        drain_wait = 0;
        while (replies_due != 0 && drain_wait < 256) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && replies_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
